// ===== sv/scs_pkg.sv =====
package scs_pkg;

   // Channels on each of the two buses (16 to 128)
   localparam int CHANNELS_PER_BUS = 128;
   localparam int BUS_COUNT        = 2;
   localparam int BITS_PER_CHANNEL = 8;

   localparam int CHAN_W   = 7;
   localparam int BYTE_W   = BITS_PER_CHANNEL;
   localparam int BIT_W    = $clog2(BITS_PER_CHANNEL);
   localparam int SENSOR_W = 11;
   localparam int IDX_W    = $clog2(CHANNELS_PER_BUS);
   localparam int ADDR_W   = IDX_W + 1;
   // Store is addressed by {bus, channel}, so it spans the full address range
   localparam int ENTRIES  = 1 << ADDR_W;

   localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS_PER_BUS);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // Work handed from the compare stage to the event emitter
   typedef struct packed {
      logic              bus;
      logic [CHAN_W-1:0] chan;
      byte_type          value;
      byte_type          mask;
   } emit_load_type;

endpackage

// ===== sv/scs_if.sv =====
interface scs_req_if;
   logic                       valid;
   logic                       ready;
   logic                       bus_select;
   logic [scs_pkg::CHAN_W-1:0] channel;
   logic [scs_pkg::BYTE_W-1:0] channel_value;

   modport source (output valid, output bus_select, output channel, output channel_value,
                   input ready);
   modport sink   (input valid, input bus_select, input channel, input channel_value,
                   output ready);
endinterface

interface scs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         event_bus;
   logic [scs_pkg::SENSOR_W-1:0] sensor_number;
   logic                         sensor_level;
   logic                         last_event;

   modport source (output valid, output event_bus, output sensor_number,
                   output sensor_level, output last_event, input ready);
   modport sink   (input valid, input event_bus, input sensor_number,
                   input sensor_level, input last_event, output ready);
endinterface

// ===== sv/sensor_change_event_scanner.sv =====
// Change-of-state scanner for polled sensor bytes.
//
// req: one word per polled byte (bus_select, channel, channel_value). The
// byte is compared with the level stored for that bus and channel; each
// differing bit, from bit 0 upward, becomes one rsp word carrying the bus,
// sensor number channel*8+bit+1, the new level and a last-event marker.
// The new byte is then stored. Unchanged bytes and channels beyond the
// bus give no words.
//
// Latency: the first event passes through the compare stage, fed by the
// level memory read taken as the word is accepted, and then through the
// emitter register.
// Throughput: one event per cycle while rsp is ready; a byte with k changed
// bits holds the emitter until its k events are out. Unchanged bytes pass
// at one per cycle. The single emitter sets the rate.
// Reset: synchronous; all stored levels read as zero afterwards, no
// clearing pass needed. When rsp stalls, the emitter holds its word, the
// compare stage holds a byte with changes and req.ready drops.
module sensor_change_event_scanner (
   input  logic      clock,
   input  logic      reset,
   scs_req_if.sink   req_port,
   scs_rsp_if.source rsp_port
);

   // Compare stage registers
   logic                       cmp_valid_ff, cmp_valid_in;
   logic                       cmp_bus_ff;
   logic [scs_pkg::CHAN_W-1:0] cmp_chan_ff;
   scs_pkg::byte_type          cmp_value_ff;
   logic                       cmp_range_ff;
   scs_pkg::addr_type          cmp_addr_ff;
   logic                       fwd_hit_ff;
   scs_pkg::byte_type          fwd_data_ff;

   logic                       req_fire;
   logic                       req_range;
   scs_pkg::addr_type          req_addr;
   scs_pkg::byte_type          rd_data;
   scs_pkg::byte_type          old_level;
   scs_pkg::byte_type          diff;
   logic                       cmp_advance;
   logic                       store_en;
   logic                       emit_free;
   logic                       emit_load_en;
   scs_pkg::emit_load_type     emit_load;

   assign req_fire  = req_port.valid && req_port.ready;
   assign req_range = {1'b0, req_port.channel} < scs_pkg::CHAN_LIMIT;
   assign req_addr  = {req_port.bus_select, req_port.channel[scs_pkg::IDX_W-1:0]};

   // Read the stored level as the word enters
   scs_level_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (rd_data),
      .wr_en   (store_en),
      .wr_addr (cmp_addr_ff),
      .wr_data (cmp_value_ff)
   );

   // Take the byte being written back in the same cycle when addresses match
   assign old_level = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign diff      = cmp_range_ff ? (old_level ^ cmp_value_ff) : '0;

   // Unchanged bytes pass without waiting for the emitter
   assign cmp_advance  = cmp_valid_ff && ((diff == '0) || emit_free);
   assign store_en     = cmp_advance && cmp_range_ff;
   assign emit_load_en = cmp_advance && (diff != '0);

   assign emit_load.bus   = cmp_bus_ff;
   assign emit_load.chan  = cmp_chan_ff;
   assign emit_load.value = cmp_value_ff;
   assign emit_load.mask  = diff;

   assign req_port.ready = !cmp_valid_ff || cmp_advance;

   always_comb begin
      cmp_valid_in = cmp_valid_ff;
      if (req_fire) begin
         cmp_valid_in = 1'b1;
      end else if (cmp_advance) begin
         cmp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmp_bus_ff   <= req_port.bus_select;
         cmp_chan_ff  <= req_port.channel;
         cmp_value_ff <= req_port.channel_value;
         cmp_range_ff <= req_range;
         cmp_addr_ff  <= req_addr;
         fwd_hit_ff   <= store_en && (cmp_addr_ff == req_addr);
         fwd_data_ff  <= cmp_value_ff;
      end
   end

   scs_emitter u_emitter (
      .clock   (clock),
      .reset   (reset),
      .load_en (emit_load_en),
      .load    (emit_load),
      .free    (emit_free),
      .rsp     (rsp_port)
   );

`ifndef ASSERT_OFF
   // Never overwrite events still waiting in the emitter
   assert property (@(posedge clock) disable iff (reset) emit_load_en |-> emit_free)
      else $error("emitter loaded while busy");

   // Write back only from an occupied, in-range compare stage
   assert property (@(posedge clock) disable iff (reset)
                    store_en |-> (cmp_valid_ff && cmp_range_ff))
      else $error("level written without a valid byte");

   // A loaded emitter offers a word in the next cycle
   assert property (@(posedge clock) disable iff (reset) emit_load_en |=> rsp_port.valid)
      else $error("loaded emitter offers no word");

   // An empty compare stage always takes a new word
   assert property (@(posedge clock) disable iff (reset) !cmp_valid_ff |-> req_port.ready)
      else $error("idle compare stage refuses input");
`endif

endmodule

// ===== sv/scs_level_store.sv =====
module scs_level_store (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  scs_pkg::addr_type  rd_addr,
   output scs_pkg::byte_type  rd_data,
   input  logic               wr_en,
   input  scs_pkg::addr_type  wr_addr,
   input  scs_pkg::byte_type  wr_data
);

   scs_pkg::byte_type              mem [scs_pkg::ENTRIES];
   logic [scs_pkg::ENTRIES-1:0]    written_ff;
   scs_pkg::byte_type              rd_ff;
   logic                           rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_ff : '0;

endmodule

// ===== sv/scs_emitter.sv =====
module scs_emitter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_en,
   input  scs_pkg::emit_load_type load,
   output logic                   free,
   scs_rsp_if.source              rsp
);

   scs_pkg::byte_type          mask_ff,  mask_in;
   scs_pkg::byte_type          value_ff;
   logic                       bus_ff;
   logic [scs_pkg::CHAN_W-1:0] chan_ff;
   logic [scs_pkg::BIT_W-1:0]  low_bit;
   scs_pkg::byte_type          mask_rest;
   logic                       fire;

   // Lowest pending bit goes out first
   always_comb begin
      low_bit = '0;
      for (int i = scs_pkg::BITS_PER_CHANNEL - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_bit = scs_pkg::BIT_W'(i);
         end
      end
   end

   assign mask_rest = mask_ff & (mask_ff - scs_pkg::BYTE_W'(1));
   assign fire      = rsp.valid && rsp.ready;
   assign free      = (mask_ff == '0) || (fire && (mask_rest == '0));

   assign rsp.valid         = (mask_ff != '0);
   assign rsp.event_bus     = bus_ff;
   assign rsp.sensor_number = {1'b0, chan_ff, low_bit} + scs_pkg::SENSOR_W'(1);
   assign rsp.sensor_level  = value_ff[low_bit];
   assign rsp.last_event    = (mask_rest == '0);

   always_comb begin
      mask_in = mask_ff;
      if (load_en) begin
         mask_in = load.mask;
      end else if (fire) begin
         mask_in = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         value_ff <= load.value;
         bus_ff   <= load.bus;
         chan_ff  <= load.chan;
      end
   end

endmodule

// ===== tb/sensor_change_event_scanner_tb.sv =====
`timescale 1ns / 100ps

module sensor_change_event_scanner_tb;
   import scs_pkg::*;

   // Worst case: ~210 words, 8 events each, each event waiting out a long
   // receiver stall, plus long sender gaps. The limit allows several times
   // that worst case.
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int RANDOM_WORDS = 190;
   localparam int HOT_SLOTS    = 6;
   localparam int NONE         = -1;
   // Settling margin after the last event, also for words that give none
   localparam int SETTLE_CYCLES = 16;

   typedef struct {
      logic                bus;
      logic [SENSOR_W-1:0] sensor;
      logic                level;
      logic                last;
   } sensor_event_type;

   // Directed stimulus: bus, channel, byte, and where obvious the event
   // count and first sensor number (NONE leaves it to the predictor).
   typedef struct packed {
      bit              bus;
      bit [CHAN_W-1:0] chan;
      bit [BYTE_W-1:0] value;
      int              n_events;
      int              first_sensor;
   } poll_row_type;

   poll_row_type poll_table [21] = '{
      '{1'b0,   7'd0, 8'h00,    0,  NONE},  // unchanged against reset levels
      '{1'b0,   7'd0, 8'h01,    1,     1},
      '{1'b0,   7'd0, 8'h01,    0,  NONE},  // same byte again
      '{1'b0,   7'd0, 8'h00,    1,     1},
      '{1'b1, 7'd127, 8'hFF,    8,  1017},  // top channel, all bits rise
      '{1'b1, 7'd127, 8'h00,    8,  1017},  // and all fall
      '{1'b0, 7'd127, 8'h80,    1,  1024},  // highest sensor number
      '{1'b1,   7'd0, 8'hFF,    8,     1},
      '{1'b1,   7'd0, 8'hFF,    0,  NONE},
      '{1'b0,   7'd0, 8'hAA,    4,     2},
      '{1'b0,   7'd0, 8'h55,    8,     1},
      '{1'b1,   7'd1, 8'h80,    1,    16},
      '{1'b0,  7'd85, 8'h5A, NONE,  NONE},
      '{1'b0,  7'd42, 8'hA5, NONE,  NONE},
      '{1'b1,  7'd85, 8'h5A, NONE,  NONE},  // same channel, other bus
      '{1'b0,  7'd85, 8'hA5, NONE,  NONE},
      '{1'b1,   7'd0, 8'h7E, NONE,  NONE},  // only the end bits change
      '{1'b0, 7'd127, 8'h7F, NONE,  NONE},
      '{1'b1,  7'd64, 8'h10,    1,   517},
      '{1'b0,  7'd64, 8'h01,    1,   513},
      '{1'b1,  7'd64, 8'h10,    0,  NONE}
   };

   logic clock;
   logic reset;

   scs_req_if req_if ();
   scs_rsp_if rsp_if ();

   sensor_change_event_scanner dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   // Predictor state: the last byte seen per bus and channel
   byte_type         known_bytes [ENTRIES];
   sensor_event_type pending_events [$];

   int  errors;
   int  cycle_count;
   int  words_sent;
   int  silent_words;
   int  full_words;
   int  events_seen;
   bit  calm;  // no idling on either side while set

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stop a hung run
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t ns: timed out with %0d events outstanding", $time, pending_events.size());
      $display("sensor_change_event_scanner test failed");
      $finish;
   end

   function automatic void check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
         errors++;
      end
   endfunction

   // Compare the byte with its stored level, queue one event per changed bit
   // from bit 0 upward, mark the highest one last, then store the byte.
   function automatic int predict_sensor_events(input logic bus, input logic [CHAN_W-1:0] chan,
                                                input byte_type fresh, output int first_sensor);
      byte_type         changed;
      int               slot;
      int               top;
      int               n;
      sensor_event_type ev;
      first_sensor = NONE;
      n            = 0;
      top          = 0;
      // Channels beyond the bus are dropped without touching any level
      if (int'(chan) >= CHANNELS_PER_BUS)
         return 0;
      slot    = int'(bus) * CHANNELS_PER_BUS + int'(chan);
      changed = fresh ^ known_bytes[slot];
      for (int b = 0; b < BITS_PER_CHANNEL; b++)
         if (changed[b])
            top = b;
      for (int b = 0; b < BITS_PER_CHANNEL; b++) begin
         if (changed[b]) begin
            ev.bus    = bus;
            ev.sensor = SENSOR_W'(int'(chan) * BITS_PER_CHANNEL + b + 1);
            ev.level  = fresh[b];
            ev.last   = (b == top);
            pending_events.push_back(ev);
            if (n == 0)
               first_sensor = int'(ev.sensor);
            n++;
         end
      end
      known_bytes[slot] = fresh;
      return n;
   endfunction

   // Mostly back to back, often a short gap, now and then a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm)
         return 0;
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Entered and left at a falling edge. valid is dropped only when a gap
   // is taken, so it is never lowered and raised in the same step.
   task automatic send_poll(input logic bus, input logic [CHAN_W-1:0] chan,
                            input byte_type value, output int n_events,
                            output int first_sensor);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.bus_select    <= bus;
      req_if.channel       <= chan;
      req_if.channel_value <= value;
      // Hold the word until it is taken
      do
         @(posedge clock);
      while (!req_if.ready);
      n_events = predict_sensor_events(bus, chan, value, first_sensor);
      words_sent++;
      if (n_events == 0)
         silent_words++;
      if (n_events == BITS_PER_CHANNEL)
         full_words++;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every queued event has come out
   task automatic drain_events();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_events.size() != 0)
         @(negedge clock);
   endtask

   // Receiver: stretches of ready, broken by stalls of random length
   initial begin : rsp_throttle
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
   end

   // Check every accepted event against the oldest one predicted
   always @(posedge clock) begin : event_monitor
      sensor_event_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_events.size() == 0) begin
            $display("%0t ns: unexpected event, expected none, got bus %0d sensor %0d level %0d",
                     $time, rsp_if.event_bus, rsp_if.sensor_number, rsp_if.sensor_level);
            errors++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_bus", int'(want.bus), int'(rsp_if.event_bus));
            check_field("sensor_number", int'(want.sensor), int'(rsp_if.sensor_number));
            check_field("sensor_level", int'(want.level), int'(rsp_if.sensor_level));
            check_field("last_event", int'(want.last), int'(rsp_if.last_event));
         end
         events_seen++;
      end
   end

   initial begin : stimulus
      logic                bus;
      logic [CHAN_W-1:0]   chan;
      byte_type            value;
      byte_type            stored;
      int                  n_events;
      int                  first_sensor;
      int                  pick;
      int                  slot;
      logic                hot_bus  [HOT_SLOTS];
      logic [CHAN_W-1:0]   hot_chan [HOT_SLOTS];

      errors       = 0;
      words_sent   = 0;
      silent_words = 0;
      full_words   = 0;
      events_seen  = 0;
      calm         = 1'b0;
      foreach (known_bytes[i])
         known_bytes[i] = '0;

      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.bus_select    = 1'b0;
      req_if.channel       = '0;
      req_if.channel_value = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the table, check the typed rows on the spot
      foreach (poll_table[i]) begin
         send_poll(poll_table[i].bus, poll_table[i].chan, poll_table[i].value,
                   n_events, first_sensor);
         if (poll_table[i].n_events != NONE)
            check_field("event count", poll_table[i].n_events, n_events);
         if (poll_table[i].first_sensor != NONE)
            check_field("first sensor", poll_table[i].first_sensor, first_sensor);
      end

      // Random part: most words revisit a small set of busy channels so that
      // bytes change against what is stored; the rest are repeats and noise.
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 50 == 0) begin
            foreach (hot_chan[h]) begin
               hot_bus[h]  = 1'($urandom_range(1));
               hot_chan[h] = CHAN_W'($urandom_range(CHANNELS_PER_BUS - 1));
            end
            // keep the edge channels in play
            hot_chan[0] = '0;
            hot_chan[1] = CHAN_W'(CHANNELS_PER_BUS - 1);
         end
         calm = (k >= 60 && k < 90);
         if (k == 100 || k == 170)
            drain_events();

         pick = $urandom_range(99);
         if (pick < 85) begin
            slot   = $urandom_range(HOT_SLOTS - 1);
            bus    = hot_bus[slot];
            chan   = hot_chan[slot];
            stored = known_bytes[int'(bus) * CHANNELS_PER_BUS + int'(chan)];
            pick   = $urandom_range(99);
            if (pick < 15)
               value = stored;                                // unchanged byte
            else if (pick < 50)
               value = stored ^ (byte_type'(1) << $urandom_range(7));
            else if (pick < 75)
               value = stored ^ byte_type'($urandom_range(255));
            else if (pick < 88)
               value = ~stored;                               // every bit flips
            else
               value = byte_type'($urandom_range(255));
         end else begin
            bus   = 1'($urandom_range(1));
            chan  = CHAN_W'($urandom_range((1 << CHAN_W) - 1));
            value = byte_type'($urandom_range(255));
         end
         send_poll(bus, chan, value, n_events, first_sensor);
      end
      calm = 1'b0;

      // Drop valid, let the tail drain, then allow the pipeline to settle
      req_if.valid <= 1'b0;
      while (pending_events.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d polled words (%0d with no change, %0d with all eight bits changed)",
               words_sent, silent_words, full_words);
      $display("and %0d sensor events under random gaps and stalls on both sides.", events_seen);
      if (errors == 0)
         $display("sensor_change_event_scanner test passed");
      else
         $display("sensor_change_event_scanner test failed");
      $finish;
   end

endmodule
